// ===== hdl/fixed_capacity_search_list_assert.svh =====
// Assertion macros used by the checker module of the search list.
`ifndef FIXED_CAPACITY_SEARCH_LIST_ASSERT_SVH
`define FIXED_CAPACITY_SEARCH_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FSL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("search list check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FSL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("search list check failed");

`endif

// ===== hdl/fsl_pkg.sv =====
// Shared types and constants of the fixed-capacity search list.
package fsl_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 32;

	// Request codes
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NOP    = 2'd3
	} fsl_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_SCAN,
		ST_SHIFT,
		ST_RESULT
	} fsl_state_t;

	// Result handoff from sequencer to output register
	typedef struct packed {
		logic load;
		logic done;
	} fsl_res_ctl_t;

endpackage

// ===== hdl/fsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fsl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/fsl_seq.sv =====
// Request sequencer: insert, linear scan and shift-down compaction over the slot RAM.
module fsl_seq #(
	parameter int DEPTH = fsl_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [1:0]                 req_type,
	input  logic [fsl_pkg::KEY_W-1:0]  key,
	input  logic                       out_free,
	output fsl_pkg::fsl_res_ctl_t      res,
	output logic [$clog2(DEPTH)-1:0]   res_pos,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       ram_we,
	output logic [$clog2(DEPTH)-1:0]   ram_waddr,
	output logic [fsl_pkg::KEY_W-1:0]  ram_wdata,
	output logic [$clog2(DEPTH)-1:0]   ram_raddr,
	input  logic [fsl_pkg::KEY_W-1:0]  ram_rdata
);
	import fsl_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	fsl_state_t          state_q, state_d;
	fsl_op_t             op_q;
	logic [KEY_W-1:0]    key_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    idx_q;     // next read address
	logic [IDX_W-1:0]    cur_q;     // index of the data now on ram_rdata
	logic                pend_q;    // ram_rdata holds entry cur_q
	logic                done_q;
	logic [IDX_W-1:0]    pos_q;

	logic [CNT_W-1:0]    cnt_m1;
	logic [IDX_W-1:0]    last_idx;
	logic                issue;
	logic                hit;
	logic                at_last;
	logic                has_room;

	// Scan status
	assign cnt_m1   = count_q - 1'b1;
	assign last_idx = cnt_m1[IDX_W-1:0];
	assign issue    = (idx_q < count_q);
	assign hit      = pend_q && (ram_rdata == key_q);
	assign at_last  = pend_q && (cur_q == last_idx);
	assign has_room = (count_q < DEPTH_C);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (fsl_op_t'(req_type))
						OP_INSERT: state_d = ST_INSERT;
						OP_REMOVE,
						OP_SEARCH: state_d = (count_q == '0) ? ST_RESULT : ST_SCAN;
						OP_NOP:    state_d = ST_RESULT;
					endcase
				end
			end
			ST_INSERT: state_d = ST_RESULT;
			ST_SCAN: begin
				if (hit) begin
					state_d = (op_q == OP_REMOVE && cur_q != last_idx) ? ST_SHIFT : ST_RESULT;
				end else if (at_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_SHIFT: begin
				if (at_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and RAM port drive
	always_comb begin
		req_ready = (state_q == ST_IDLE);
		ram_raddr = idx_q[IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = cur_q - 1'b1;
		ram_wdata = ram_rdata;
		res.load  = (state_q == ST_RESULT) && out_free;
		res.done  = done_q;
		res_pos   = pos_q;
		count     = count_q;
		unique case (state_q)
			ST_INSERT: begin
				ram_we    = has_room;
				ram_waddr = count_q[IDX_W-1:0];
				ram_wdata = key_q;
			end
			ST_SHIFT: begin
				ram_we = pend_q;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
				end
				ST_INSERT: begin
					if (has_room) begin
						count_q <= count_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (hit && op_q == OP_REMOVE && cur_q != last_idx) begin
						// restart reads at the entry after the match
						idx_q  <= CNT_W'(cur_q) + 1'b1;
						pend_q <= 1'b0;
					end else begin
						pend_q <= issue;
						if (issue) begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (hit && op_q == OP_REMOVE && cur_q == last_idx) begin
						count_q <= cnt_m1;
					end
				end
				ST_SHIFT: begin
					if (at_last) begin
						count_q <= cnt_m1;
						pend_q  <= 1'b0;
					end else begin
						pend_q <= issue;
						if (issue) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Request payload and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					op_q   <= fsl_op_t'(req_type);
					key_q  <= key;
					done_q <= 1'b0;
					pos_q  <= '0;
				end
			end
			ST_INSERT: begin
				if (has_room) begin
					done_q <= 1'b1;
					pos_q  <= count_q[IDX_W-1:0];
				end
			end
			ST_SCAN: begin
				if (issue) begin
					cur_q <= idx_q[IDX_W-1:0];
				end
				if (hit) begin
					done_q <= 1'b1;
					pos_q  <= cur_q;
				end
			end
			ST_SHIFT: begin
				if (issue) begin
					cur_q <= idx_q[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/fixed_capacity_search_list.sv =====
// Top level of the fixed-capacity search list: slot RAM, sequencer and result register.
//
//  channel | direction | handshake            | beat fields
//  req     | in        | req_valid/req_ready  | req_type, key
//  res     | out       | res_valid/res_ready  | done_res, position, entries_used,
//          |           |                      | is_full, list_empty
//
// An insert writes the key behind the last entry if there is room; an unused code, or a
// remove or search on an empty list, goes straight to the result. Search and remove read
// from slot 0 up to the first match or the last entry, and a remove then shifts the later
// entries down by one slot. Scans and shifts use the single read port of the slot RAM, one entry per cycle.
// Reset clears the count but not the slots; slots are never read before they are written.
// A result waits in the output register while the next request is taken; the
// sequencer holds its result when that register is still full.
module fixed_capacity_search_list #(
	parameter int DEPTH = fsl_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic [1:0]                 req_type,
	input  logic [fsl_pkg::KEY_W-1:0]  key,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic                       done_res,
	output logic [$clog2(DEPTH)-1:0]   position,
	output logic [$clog2(DEPTH+1)-1:0] entries_used,
	output logic                       is_full,
	output logic                       list_empty
);
	import fsl_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	fsl_res_ctl_t     res_ctl;
	logic [IDX_W-1:0] res_pos;
	logic [CNT_W-1:0] count;
	logic             out_free;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [KEY_W-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [KEY_W-1:0] ram_rdata;

	logic             res_valid_q;
	logic             done_res_q;
	logic [IDX_W-1:0] position_q;
	logic [CNT_W-1:0] entries_used_q;
	logic             is_full_q;
	logic             list_empty_q;

	fsl_ram #(
		.WIDTH (KEY_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fsl_seq #(
		.DEPTH (DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.key       (key),
		.out_free  (out_free),
		.res       (res_ctl),
		.res_pos   (res_pos),
		.count     (count),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Output register is free when empty or being drained this cycle
	assign out_free = !res_valid_q || res_ready;

	// Result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_ctl.load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result beat payload, status taken from the updated count
	always_ff @(posedge clk) begin
		if (res_ctl.load) begin
			done_res_q     <= res_ctl.done;
			position_q     <= res_pos;
			entries_used_q <= count;
			is_full_q      <= (count == DEPTH_C);
			list_empty_q   <= (count == '0);
		end
	end

	assign res_valid    = res_valid_q;
	assign done_res     = done_res_q;
	assign position     = position_q;
	assign entries_used = entries_used_q;
	assign is_full      = is_full_q;
	assign list_empty   = list_empty_q;

endmodule

// ===== hdl/fsl_chk.sv =====
// Port-level checker for the search list, bound to the top level.
`include "fixed_capacity_search_list_assert.svh"

module fsl_chk #(
	parameter int DEPTH = fsl_pkg::DEPTH_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic                       done_res,
	input logic [$clog2(DEPTH)-1:0]   position,
	input logic [$clog2(DEPTH+1)-1:0] entries_used,
	input logic                       is_full,
	input logic                       list_empty
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	// One request at a time: the request side closes right after a beat
	`FSL_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

	// Full flag agrees with the count
	`FSL_ASSERT_NOW(a_full_count, res_valid, is_full == (entries_used == DEPTH_C))

	// Empty flag agrees with the count, and never both flags
	`FSL_ASSERT_NOW(a_empty_count, res_valid, list_empty == (entries_used == '0) && !(is_full && list_empty))

	// A failed request reports no position
	`FSL_ASSERT_NOW(a_miss_pos, res_valid && !done_res, position == '0)

	// A stalled result beat holds
	`FSL_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(position) && $stable(entries_used))

endmodule

bind fixed_capacity_search_list fsl_chk #(.DEPTH(DEPTH)) u_fsl_chk (.*);

// ===== tb/fixed_capacity_search_list_tb.sv =====
// Self-checking testbench of the fixed-capacity search list: directed table, random requests.
module fixed_capacity_search_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fsl_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int POS_W        = $clog2(DEPTH);
	localparam int USED_W       = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 1525;
	localparam int PAUSE_AT     = 800;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 64;
	localparam int IDLE_LIMIT   = 4000;
	localparam int REPORT_MAX   = 100;

	typedef struct packed {
		logic              done;
		logic [POS_W-1:0]  pos;
		logic [USED_W-1:0] used;
		logic              full;
		logic              empty;
	} list_result_t;

	// One row of the directed table; res is only used when typed is set
	typedef struct {
		fsl_op_t          op;
		logic [KEY_W-1:0] k;
		bit               typed;
		list_result_t     res;
	} dir_row_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              req_valid    = 1'b0;
	logic              req_ready;
	logic [1:0]        req_type     = OP_NOP;
	logic [KEY_W-1:0]  key          = '0;
	logic              res_valid;
	logic              res_ready    = 1'b0;
	logic              done_res;
	logic [POS_W-1:0]  position;
	logic [USED_W-1:0] entries_used;
	logic              is_full;
	logic              list_empty;

	// Shadow copy of the list, advanced once per accepted request beat
	logic [KEY_W-1:0] list_keys [DEPTH];
	int unsigned      list_count = 0;
	list_result_t     pending_results [$];

	int unsigned mismatches   = 0;
	int unsigned results_seen = 0;
	int unsigned tally [4][2];
	int unsigned full_hits    = 0;
	int unsigned empty_hits   = 0;
	bit          calm_sender  = 1'b0;

	dir_row_t dir_rows [26] = '{
		'{OP_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 4'd0, 5'd0, 1'b0, 1'b1}},
		'{OP_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd0, 5'd0, 1'b0, 1'b1}},
		'{OP_NOP,    32'h0000_0000, 1'b1, '{1'b0, 4'd0, 5'd0, 1'b0, 1'b1}},
		'{OP_INSERT, 32'h0000_0000, 1'b1, '{1'b1, 4'd0, 5'd1, 1'b0, 1'b0}},
		'{OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd1, 5'd2, 1'b0, 1'b0}},
		'{OP_INSERT, 32'h0000_0000, 1'b1, '{1'b1, 4'd2, 5'd3, 1'b0, 1'b0}},
		'{OP_SEARCH, 32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd1, 5'd3, 1'b0, 1'b0}},
		'{OP_SEARCH, 32'h0000_0000, 1'b1, '{1'b1, 4'd0, 5'd3, 1'b0, 1'b0}},
		// duplicate: first copy goes, second moves down to slot 1
		'{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
		'{OP_SEARCH, 32'h0000_0000, 1'b0, '0},
		'{OP_INSERT, 32'h8000_0000, 1'b0, '0},
		'{OP_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
		'{OP_INSERT, 32'h0000_0001, 1'b0, '0},
		'{OP_INSERT, 32'hFFFF_FFFE, 1'b0, '0},
		'{OP_INSERT, 32'h5555_5555, 1'b0, '0},
		'{OP_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
		'{OP_INSERT, 32'h0F0F_0F0F, 1'b0, '0},
		'{OP_INSERT, 32'hF0F0_F0F0, 1'b0, '0},
		'{OP_INSERT, 32'h1234_5678, 1'b0, '0},
		'{OP_INSERT, 32'h8765_4321, 1'b0, '0},
		'{OP_INSERT, 32'h0000_FFFF, 1'b0, '0},
		'{OP_INSERT, 32'hFFFF_0000, 1'b0, '0},
		'{OP_INSERT, 32'h00FF_00FF, 1'b0, '0},
		'{OP_INSERT, 32'hFF00_FF00, 1'b0, '0},
		// list is full now: insert is dropped
		'{OP_INSERT, 32'h0000_00AA, 1'b1, '{1'b0, 4'd0, 5'd16, 1'b1, 1'b0}},
		// head removal shifts all remaining entries
		'{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '0}
	};

	fixed_capacity_search_list #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.key(key),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.done_res(done_res),
		.position(position),
		.entries_used(entries_used),
		.is_full(is_full),
		.list_empty(list_empty)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one request to the shadow list and return the result it should give
	function automatic list_result_t apply_request(fsl_op_t op, logic [KEY_W-1:0] k);
		list_result_t r;
		int hit_at;
		r = '0;
		hit_at = -1;
		if (op == OP_REMOVE || op == OP_SEARCH) begin
			for (int i = 0; i < int'(list_count); i++)
				if (hit_at < 0 && list_keys[i] == k)
					hit_at = i;
		end
		case (op)
			OP_INSERT: begin
				if (list_count < DEPTH) begin
					list_keys[list_count] = k;
					r.pos = POS_W'(list_count);
					list_count++;
					r.done = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (hit_at >= 0) begin
					for (int i = hit_at; i + 1 < int'(list_count); i++)
						list_keys[i] = list_keys[i + 1];
					list_count--;
					r.pos = POS_W'(hit_at);
					r.done = 1'b1;
				end
			end
			OP_SEARCH: begin
				if (hit_at >= 0) begin
					r.pos = POS_W'(hit_at);
					r.done = 1'b1;
				end
			end
			default: ;
		endcase
		r.used  = USED_W'(list_count);
		r.full  = (list_count == DEPTH);
		r.empty = (list_count == 0);
		return r;
	endfunction

	// Idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		if (sel < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Keys lean toward stored ones and a small pool so that lookups hit
	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40 && list_count > 0)
			return list_keys[$urandom_range(0, list_count - 1)];
		if (sel < 60)
			return $urandom_range(0, 7);
		if (sel < 70) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return '1;
				2: return 32'h8000_0000;
				default: return 32'h7FFF_FFFF;
			endcase
		end
		return $urandom();
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	// Offer one request beat, wait for it to be taken, then record what it should give
	task automatic send_request(fsl_op_t op, logic [KEY_W-1:0] k, bit typed, list_result_t typed_res);
		int gap;
		list_result_t r;
		gap = calm_sender ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= op;
		key       <= k;
		do @(posedge clk); while (!req_ready);
		r = apply_request(op, k);
		tally[op][r.done]++;
		if (op == OP_INSERT && r.done && r.full)
			full_hits++;
		if (op == OP_REMOVE && r.done && r.empty)
			empty_hits++;
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Request side: reset, directed table, random requests, then the wind-down
	initial begin
		bit filling;
		fsl_op_t op;
		int sel;
		foreach (tally[i, j])
			tally[i][j] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].op, dir_rows[i].k, dir_rows[i].typed, dir_rows[i].res);
		drain_results();

		filling = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				calm_sender = ($urandom_range(0, 3) == 0);
			if (n == PAUSE_AT)
				drain_results();
			// sweep the fill level between empty and full
			if (list_count == DEPTH && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (list_count == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 99) == 0)
				filling = !filling;
			sel = $urandom_range(0, 99);
			if (sel < 4)
				op = OP_NOP;
			else if (sel < 30)
				op = OP_SEARCH;
			else if (sel < (filling ? 82 : 48))
				op = OP_INSERT;
			else
				op = OP_REMOVE;
			send_request(op, pick_key(), 1'b0, '0);
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d inserts stored, %0d dropped on a full list, %0d nops",
			RANDOM_ITEMS + $size(dir_rows), tally[OP_INSERT][1], tally[OP_INSERT][0],
			tally[OP_NOP][0]);
		$display("removes hit/miss %0d/%0d, searches hit/miss %0d/%0d, filled %0d times, emptied %0d times",
			tally[OP_REMOVE][1], tally[OP_REMOVE][0], tally[OP_SEARCH][1], tally[OP_SEARCH][0],
			full_hits, empty_hits);
		if (mismatches == 0)
			$display("PASS fixed_capacity_search_list");
		else
			$display("FAIL fixed_capacity_search_list");
		$finish;
	end

	// Result side: random back-pressure plus one long hold-off while requests keep coming
	initial begin
		int span;
		bit held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && results_seen >= HOLD_AT) begin
				held = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				span = pick_gap();
				if (span > 0) begin
					res_ready <= 1'b0;
					repeat (span) @(posedge clk);
				end
				res_ready <= 1'b1;
				span = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 12);
				repeat (span) @(posedge clk);
			end
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				if (done_res !== want.done)
					report_mismatch($sformatf("done_res %0b, expected %0b", done_res, want.done));
				if (position !== want.pos)
					report_mismatch($sformatf("position %0d, expected %0d", position, want.pos));
				if (entries_used !== want.used)
					report_mismatch($sformatf("entries_used %0d, expected %0d",
						entries_used, want.used));
				if (is_full !== want.full)
					report_mismatch($sformatf("is_full %0b, expected %0b", is_full, want.full));
				if (list_empty !== want.empty)
					report_mismatch($sformatf("list_empty %0b, expected %0b",
						list_empty, want.empty));
			end
		end
	end

	// Watchdog: too long without any beat on either side ends the run
	always @(posedge clk) begin : watchdog
		int unsigned quiet;
		if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
				$display("FAIL fixed_capacity_search_list");
				$finish;
			end
		end
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/fsl_pkg.sv
hdl/fsl_ram.sv
hdl/fsl_seq.sv
hdl/fixed_capacity_search_list.sv
hdl/fsl_chk.sv
tb/fixed_capacity_search_list_tb.sv
